/* rtl/pvd_pkg.sv */
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types, constants and the value finishing function for the prefix
// varint decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

    // head byte boundaries of the encoding forms
    localparam logic [7:0] HEAD_MAX_DIRECT = 8'd240;
    localparam logic [7:0] HEAD_TWO_LO     = 8'd241;
    localparam logic [7:0] HEAD_TWO_HI     = 8'd248;
    localparam logic [7:0] HEAD_THREE      = 8'd249;
    localparam logic [7:0] HEAD_LONG_BIAS  = 8'd247;

    // offsets added for the two and three byte forms
    localparam logic [16:0] OFFSET_TWO   = 17'd240;
    localparam logic [16:0] OFFSET_THREE = 17'd2288;

    localparam int unsigned QUEUE_DEPTH = 2;

    // one classified byte, passed from front to back through the queue
    typedef struct packed {
        logic [7:0] data;      // the byte itself
        logic       is_head;   // first byte of a value
        logic       is_final;  // completes the value
        logic       is_abort;  // buffer ended before the value completed
        logic       func;      // zigzag mode, meaningful on a head byte
    } t_q_entry;

    // trailing byte count implied by a head byte
    function automatic logic [3:0] trail_count(input logic [7:0] head);
        logic [7:0] diff;
        diff = head - HEAD_LONG_BIAS;
        if (head <= HEAD_MAX_DIRECT) begin
            trail_count = 4'd0;
        end else if (head <= HEAD_TWO_HI) begin
            trail_count = 4'd1;
        end else if (head == HEAD_THREE) begin
            trail_count = 4'd2;
        end else begin
            trail_count = diff[3:0];
        end
    endfunction

    // final value from head and collected trailing bytes, zigzag if asked
    function automatic logic [63:0] finish_value(input logic [7:0]  head,
                                                 input logic [63:0] acc,
                                                 input logic        zz);
        logic [63:0] n;
        logic [7:0]  hi;
        logic [16:0] small_sum;
        hi        = head - HEAD_TWO_LO;
        small_sum = 17'd0;
        if (head <= HEAD_MAX_DIRECT) begin
            n = {56'd0, head};
        end else if (head <= HEAD_TWO_HI) begin
            small_sum = OFFSET_TWO + {6'd0, hi[2:0], acc[7:0]};
            n = {47'd0, small_sum};
        end else if (head == HEAD_THREE) begin
            small_sum = OFFSET_THREE + {1'b0, acc[15:0]};
            n = {47'd0, small_sum};
        end else begin
            n = acc;
        end
        if (zz) begin
            finish_value = {1'b0, n[63:1]} ^ {64{n[0]}};
        end else begin
            finish_value = n;
        end
    endfunction

endpackage

/* rtl/prefix_varint_decoder.sv */
// Path: a completing byte passes the two entry queue, then the output register.
// Throughput: one byte per cycle unless output stalls; the front counts trailing
// bytes, the back shifts one byte into the accumulator per cycle, queue between.
// Reset: synchronous, active low; clears the byte count, queue and output valid.
// ----------------------------------------------------------------------------
// prefix_varint_decoder
// Decodes a byte stream of prefix varints, optionally zigzag signed, into
// one 64-bit result per value, with a short-buffer status.
// ----------------------------------------------------------------------------
module prefix_varint_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_data
    input  logic        i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [63:0] value, [67:64] length, [71:68] zero
    output logic        o_m_tuser    // [0] status
);
    import pvd_pkg::*;

    logic     w_push;
    logic     w_q_ready;
    t_q_entry w_push_entry;
    logic     w_q_valid;
    logic     w_pop;
    t_q_entry w_pop_entry;

    // classification
    pvd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .i_q_ready  (w_q_ready),
        .o_q_valid  (w_push),
        .o_q_entry  (w_push_entry)
    );

    // decoupling queue
    pvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_pop_entry)
    );

    // accumulation and result
    pvd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_entry  (w_pop_entry),
        .o_q_pop    (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

/* rtl/pvd_front.sv */
// ----------------------------------------------------------------------------
// pvd_front
// Accepts stream bytes and classifies each as head, trailing, final or
// aborted by tracking the trailing bytes still expected.
// ----------------------------------------------------------------------------
module pvd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] data_byte
    input  logic              i_s_tlast,
    input  logic              i_s_tuser,   // [0] func
    input  logic              i_q_ready,
    output logic              o_q_valid,
    output pvd_pkg::t_q_entry o_q_entry
);
    import pvd_pkg::*;

    logic [3:0] r_remaining;
    logic [3:0] n_remaining;
    logic [3:0] w_rem_after;
    logic       w_head;
    logic       w_final;
    logic       w_abort;

    // classify the incoming byte
    always_comb begin
        w_head      = (r_remaining == 4'd0);
        w_rem_after = w_head ? trail_count(i_s_tdata) : (r_remaining - 4'd1);
        w_final     = (w_rem_after == 4'd0);
        w_abort     = !w_final && i_s_tlast;
        n_remaining = (w_final || w_abort) ? 4'd0 : w_rem_after;
    end

    assign o_s_tready = i_q_ready;
    assign o_q_valid  = i_s_tvalid;

    always_comb begin
        o_q_entry.data     = i_s_tdata;
        o_q_entry.is_head  = w_head;
        o_q_entry.is_final = w_final;
        o_q_entry.is_abort = w_abort;
        o_q_entry.func     = i_s_tuser;
    end

    // remaining count advances on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 4'd0;
        end else if (i_s_tvalid && i_q_ready) begin
            r_remaining <= n_remaining;
        end
    end

endmodule

/* rtl/pvd_queue.sv */
// ----------------------------------------------------------------------------
// pvd_queue
// Two entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module pvd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pvd_pkg::t_q_entry i_entry,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output pvd_pkg::t_q_entry o_entry
);
    import pvd_pkg::*;

    t_q_entry   r_mem [QUEUE_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_count != 2'(QUEUE_DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/pvd_back.sv */
// ----------------------------------------------------------------------------
// pvd_back
// Collects trailing bytes into the accumulator, finishes each value and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module pvd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  pvd_pkg::t_q_entry i_q_entry,
    output logic              o_q_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [71:0]       o_m_tdata,   // [63:0] value, [67:64] length, [71:68] zero
    output logic              o_m_tuser    // [0] status
);
    import pvd_pkg::*;

    logic [7:0]  r_head;
    logic [63:0] r_acc;
    logic        r_signed;
    logic [3:0]  r_taken;
    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic [3:0]  r_out_length;
    logic        r_out_status;

    logic [7:0]  w_head;
    logic [63:0] w_acc;
    logic        w_signed;
    logic [3:0]  w_taken;
    logic        w_emit;

    // state after taking the byte at the queue head
    always_comb begin
        if (i_q_entry.is_head) begin
            w_head   = i_q_entry.data;
            w_acc    = 64'd0;
            w_signed = i_q_entry.func;
            w_taken  = 4'd1;
        end else begin
            w_head   = r_head;
            w_acc    = {r_acc[55:0], i_q_entry.data};
            w_signed = r_signed;
            w_taken  = r_taken + 4'd1;
        end
    end

    assign o_q_pop = i_q_valid && (!r_out_valid || i_m_tready);
    assign w_emit  = o_q_pop && (i_q_entry.is_final || i_q_entry.is_abort);

    // value state
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_head   <= w_head;
            r_acc    <= w_acc;
            r_signed <= w_signed;
            r_taken  <= w_taken;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_length <= w_taken;
            r_out_status <= !i_q_entry.is_final;
            r_out_value  <= i_q_entry.is_final ? finish_value(w_head, w_acc, w_signed)
                                               : 64'd0;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_length, r_out_value};
    assign o_m_tuser  = r_out_status;

endmodule

/* rtl/pvd_checker.sv */
// ----------------------------------------------------------------------------
// pvd_checker
// Port-level checks on the prefix varint decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic        o_m_tuser
);

    // output is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    // short-buffer results carry a zero value
    a_abort_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[63:0] == 64'd0)
        else $error("short-buffer result with non-zero value");

    // encoded length is one to nine bytes, padding zero
    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[67:64] != 4'd0 && o_m_tdata[67:64] <= 4'd9
                       && o_m_tdata[71:68] == 4'd0)
        else $error("result length out of range");

    // a short buffer ends no later than the eighth byte
    a_abort_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[67:64] <= 4'd8)
        else $error("short-buffer result too long");

endmodule

bind prefix_varint_decoder pvd_checker u_pvd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
